[sv/chm_pkg.sv]
// ----------------------------------------------------------------------------
// chm_pkg
// Types and constants shared by the cycle health monitor modules.
// ----------------------------------------------------------------------------
package chm_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 63;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_WKC   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FAIL_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WARMUP_LEN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHECK_PERIOD   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_NS      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_DEADLINE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OP_STATE_CODE  = 3'd6;

    // reset values
    localparam logic [15:0] RST_EXPECTED_WKC   = 16'd0;
    localparam logic [31:0] RST_FAIL_THRESHOLD = 32'd10;
    localparam logic [31:0] RST_WARMUP_LEN     = 32'd20;
    localparam logic [31:0] RST_CHECK_PERIOD   = 32'd200;
    localparam logic [31:0] RST_PERIOD_NS      = 32'd1000000;
    localparam logic [62:0] RST_FIRST_DEADLINE = 63'd0;
    localparam logic [7:0]  RST_OP_STATE_CODE  = 8'd8;

    localparam logic [62:0] JITTER_SAT = {63{1'b1}};

    typedef struct packed {
        logic [15:0] work_count;
        logic [7:0]  slave_state;
        logic [62:0] wake_time_ns;
    } in_item_t;

    typedef struct packed {
        logic        fault_sticky;
        logic        fault_new;
        logic        operational;
        logic        state_sampled;
        logic [31:0] bad_streak;
        logic [62:0] jitter_now;
        logic [63:0] jitter_low;
        logic [62:0] jitter_high;
        logic [63:0] overrun_total;
        logic [63:0] cycle_total;
    } out_item_t;

    typedef struct packed {
        logic [15:0] wkc_target;
        logic [31:0] fail_threshold;
        logic [31:0] warmup_len;
        logic [31:0] check_period;
        logic [31:0] nominal_period;
        logic [62:0] first_deadline_ns;
        logic [7:0]  op_state_code;
    } cfg_t;

    // health block results
    typedef struct packed {
        logic        fault_sticky;
        logic        fault_new;
        logic        operational;
        logic        state_sampled;
        logic [31:0] bad_streak;
        logic [63:0] cycle_total;
    } health_res_t;

    // timing block results
    typedef struct packed {
        logic [62:0] jitter_now;
        logic [63:0] jitter_low;
        logic [62:0] jitter_high;
        logic [63:0] overrun_total;
    } timing_res_t;

endpackage

[sv/fieldbus_cycle_health_monitor.sv]
// ----------------------------------------------------------------------------
// fieldbus_cycle_health_monitor
// Per-bus-cycle health check: working counter, slave state, wake jitter.
// ----------------------------------------------------------------------------
// Pipeline: an accepted item passes through the input register, then the
//   result register, before its result shows on m_*.
// Throughput: one item per clock; the input register refills while the
//   result register is taken, stalls only when m_ready is low with both full.
// Reset: synchronous, active low on aresetn; config registers return to their
//   defaults, state and counters clear, both pipeline registers empty.
// ----------------------------------------------------------------------------
module fieldbus_cycle_health_monitor
    import chm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // input items, one per bus cycle
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_item,
    // result items
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_item,
    // configuration writes
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // configuration registers
    cfg_t cfg_reg;

    // input register
    logic     in_valid_reg;
    in_item_t in_item_reg;

    // result register
    logic      out_valid_reg;
    out_item_t out_item_reg;

    logic        advance;
    logic        cycles_zero;
    logic        load_state;
    logic        load_deadline;
    health_res_t health_res;
    timing_res_t timing_res;

    // The item in the input register is processed and its state committed in
    // the cycle it moves into the result register.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    // Before the first item, writing first_deadline_ns or op_state_code also
    // presets the running deadline / latched state.
    assign load_state    = cfg_we && (cfg_index == REG_OP_STATE_CODE) && cycles_zero;
    assign load_deadline = cfg_we && (cfg_index == REG_FIRST_DEADLINE) && cycles_zero;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.wkc_target        <= RST_EXPECTED_WKC;
            cfg_reg.fail_threshold    <= RST_FAIL_THRESHOLD;
            cfg_reg.warmup_len        <= RST_WARMUP_LEN;
            cfg_reg.check_period      <= RST_CHECK_PERIOD;
            cfg_reg.nominal_period    <= RST_PERIOD_NS;
            cfg_reg.first_deadline_ns <= RST_FIRST_DEADLINE;
            cfg_reg.op_state_code     <= RST_OP_STATE_CODE;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_EXPECTED_WKC:   cfg_reg.wkc_target        <= cfg_wdata[15:0];
                REG_FAIL_THRESHOLD: cfg_reg.fail_threshold    <= cfg_wdata[31:0];
                REG_WARMUP_LEN:     cfg_reg.warmup_len        <= cfg_wdata[31:0];
                REG_CHECK_PERIOD:   cfg_reg.check_period      <= cfg_wdata[31:0];
                REG_PERIOD_NS:      cfg_reg.nominal_period    <= cfg_wdata[31:0];
                REG_FIRST_DEADLINE: cfg_reg.first_deadline_ns <= cfg_wdata;
                REG_OP_STATE_CODE:  cfg_reg.op_state_code     <= cfg_wdata[7:0];
                default: begin
                    // unmapped index: ignored
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    chm_health u_health (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step           (advance),
        .work_count     (in_item_reg.work_count),
        .slave_state    (in_item_reg.slave_state),
        .cfg            (cfg_reg),
        .load_state     (load_state),
        .load_state_val (cfg_wdata[7:0]),
        .cycles_zero    (cycles_zero),
        .res            (health_res)
    );

    chm_timing u_timing (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .step              (advance),
        .wake_time_ns      (in_item_reg.wake_time_ns),
        .nominal_period    (cfg_reg.nominal_period),
        .load_deadline     (load_deadline),
        .load_deadline_val (cfg_wdata),
        .res               (timing_res)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_item_reg.fault_sticky  <= health_res.fault_sticky;
            out_item_reg.fault_new     <= health_res.fault_new;
            out_item_reg.operational   <= health_res.operational;
            out_item_reg.state_sampled <= health_res.state_sampled;
            out_item_reg.bad_streak    <= health_res.bad_streak;
            out_item_reg.cycle_total   <= health_res.cycle_total;
            out_item_reg.jitter_now    <= timing_res.jitter_now;
            out_item_reg.jitter_low    <= timing_res.jitter_low;
            out_item_reg.jitter_high   <= timing_res.jitter_high;
            out_item_reg.overrun_total <= timing_res.overrun_total;
        end
    end

endmodule

[sv/chm_health.sv]
// ----------------------------------------------------------------------------
// chm_health
// State latch, bad-cycle streak, sticky fault and cycle count.
// ----------------------------------------------------------------------------
module chm_health
    import chm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  logic [15:0] work_count,
    input  logic [7:0]  slave_state,
    input  cfg_t        cfg,
    input  logic        load_state,
    input  logic [7:0]  load_state_val,
    output logic        cycles_zero,
    output health_res_t res
);

    logic [31:0] check_cnt_reg,   check_cnt_next;
    logic [7:0]  latched_reg,     latched_next;
    logic [31:0] streak_reg,      streak_next;
    logic        fault_reg,       fault_next;
    logic [63:0] cycles_reg,      cycles_next;

    logic [31:0] cc_inc;
    logic        sampled;
    logic        wkc_low;
    logic        in_warmup;
    logic        bad;
    logic [31:0] thr;
    logic        hit;

    always_comb begin
        cc_inc         = check_cnt_reg + 32'd1;
        sampled        = (cc_inc >= cfg.check_period);
        check_cnt_next = sampled ? 32'd0 : cc_inc;
        latched_next   = sampled ? slave_state : latched_reg;

        wkc_low   = (cfg.wkc_target != 16'd0) && (work_count < cfg.wkc_target);
        in_warmup = (cycles_reg < {32'd0, cfg.warmup_len});
        bad       = !in_warmup && (wkc_low || (latched_next != cfg.op_state_code));

        if (bad) begin
            streak_next = (streak_reg == {32{1'b1}}) ? streak_reg : streak_reg + 32'd1;
        end else begin
            streak_next = 32'd0;
        end

        thr        = (cfg.fail_threshold == 32'd0) ? 32'd1 : cfg.fail_threshold;
        hit        = (streak_next >= thr);
        fault_next = fault_reg || hit;
        cycles_next = cycles_reg + 64'd1;

        res.fault_sticky  = fault_next;
        res.fault_new     = hit && !fault_reg;
        res.operational   = (streak_next == 32'd0) && (latched_next == cfg.op_state_code);
        res.state_sampled = sampled;
        res.bad_streak    = streak_next;
        res.cycle_total   = cycles_next;
    end

    assign cycles_zero = (cycles_reg == 64'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            check_cnt_reg <= 32'd0;
            latched_reg   <= RST_OP_STATE_CODE;
            streak_reg    <= 32'd0;
            fault_reg     <= 1'b0;
            cycles_reg    <= 64'd0;
        end else if (step) begin
            check_cnt_reg <= check_cnt_next;
            latched_reg   <= latched_next;
            streak_reg    <= streak_next;
            fault_reg     <= fault_next;
            cycles_reg    <= cycles_next;
        end else if (load_state) begin
            latched_reg   <= load_state_val;
        end
    end

endmodule

[sv/chm_timing.sv]
// ----------------------------------------------------------------------------
// chm_timing
// Wake jitter against the running deadline, min/max, overruns and resync.
// ----------------------------------------------------------------------------
module chm_timing
    import chm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  logic [62:0] wake_time_ns,
    input  logic [31:0] nominal_period,
    input  logic        load_deadline,
    input  logic [62:0] load_deadline_val,
    output timing_res_t res
);

    logic [63:0] deadline_reg, deadline_next;
    logic [63:0] min_reg,      min_next;
    logic [62:0] max_reg,      max_next;
    logic [63:0] late_reg,     late_next;

    logic [63:0] wake;
    logic        late;
    logic [63:0] diff;
    logic [62:0] jitter;
    logic [34:0] resync_gap;
    logic        resync;

    always_comb begin
        wake       = {1'b0, wake_time_ns};
        late       = (wake > deadline_reg);
        diff       = late ? (wake - deadline_reg) : (deadline_reg - wake);
        jitter     = diff[63] ? JITTER_SAT : diff[62:0];
        // 5 * period as shift and add
        resync_gap = {1'b0, nominal_period, 2'b00} + {3'b000, nominal_period};
        resync     = late && (diff > {29'd0, resync_gap});

        min_next  = ({1'b0, jitter} < min_reg) ? {1'b0, jitter} : min_reg;
        max_next  = (jitter > max_reg) ? jitter : max_reg;
        late_next = late ? late_reg + 64'd1 : late_reg;
        deadline_next = (resync ? wake : deadline_reg) + {32'd0, nominal_period};

        res.jitter_now    = jitter;
        res.jitter_low    = min_next;
        res.jitter_high   = max_next;
        res.overrun_total = late_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deadline_reg <= {1'b0, RST_FIRST_DEADLINE};
            min_reg      <= {64{1'b1}};
            max_reg      <= 63'd0;
            late_reg     <= 64'd0;
        end else if (step) begin
            deadline_reg <= deadline_next;
            min_reg      <= min_next;
            max_reg      <= max_next;
            late_reg     <= late_next;
        end else if (load_deadline) begin
            deadline_reg <= {1'b0, load_deadline_val};
        end
    end

endmodule

[sv/chm_checker.sv]
// ----------------------------------------------------------------------------
// chm_checker
// Port-level checks on the cycle health monitor, bound to the top level.
// ----------------------------------------------------------------------------
module chm_checker
    import chm_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_valid,
    input logic                  m_ready,
    input out_item_t             m_item
);

    logic fault_seen_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fault_seen_reg <= 1'b0;
        end else if (m_valid && m_ready && m_item.fault_sticky) begin
            fault_seen_reg <= 1'b1;
        end
    end

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    // fault latch never clears once reported
    a_fault_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && fault_seen_reg |-> m_item.fault_sticky)
        else $error("sticky fault dropped");

    // a new fault is also a latched fault; operational means no streak
    a_fault_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_item.fault_new || m_item.fault_sticky) &&
                    (!m_item.operational || (m_item.bad_streak == 32'd0)))
        else $error("inconsistent health flags");

    // current jitter lies between recorded min and max
    a_jitter_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_item.jitter_high >= m_item.jitter_now) &&
                    ({1'b0, m_item.jitter_now} >= m_item.jitter_low))
        else $error("jitter outside min/max");

    // no result straight out of reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind fieldbus_cycle_health_monitor chm_checker u_chm_checker (.*);
